>>> src/fsbp_pkg.sv
package fsbp_pkg;

  // Width of the fraction fields and of the coefficient on the ports
  localparam int unsigned IN_BITS = 32;
  localparam int unsigned COEF_BITS = 32;

  // Default working width of numerator and denominator
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Longest run of coefficients per fraction
  localparam int unsigned MAX_RESULTS = 48;
  localparam int unsigned CNT_BITS = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_DIV,
    ST_PUT
  } fsbp_state_e;

endpackage

>>> src/fsbp_div.sv
module fsbp_div #(
  parameter int unsigned W = fsbp_pkg::VALUE_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o,
  output logic [W-1:0] remainder_o
);

  localparam int unsigned CW = $clog2(W);
  localparam logic [CW-1:0] LastStep = CW'(W - 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [W:0]    r_shift;
  logic [W:0]    r_diff;
  logic          r_ge;

  // One quotient bit per cycle: shift in the next dividend bit, try to subtract
  always_comb begin
    r_shift = {rem_q, quo_q[W-1]};
    r_diff  = r_shift - {1'b0, dvs_q};
    r_ge    = (r_shift >= {1'b0, dvs_q});
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[W-2:0], r_ge};
      rem_d = r_ge ? r_diff[W-1:0] : r_shift[W-1:0];
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = busy_q && (cnt_q == LastStep);
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> src/fraction_to_stern_brocot_path_unit.sv
// Sequence: an item is taken in the idle state and checked; a zero or equal pair or a leading
// zero is registered at the output from the check state, else the divider is loaded and started.
// Each quotient comes from the bit-serial divider, one quotient bit per cycle, and its
// coefficient is registered at the output once the divider is done and the output slot is free;
// the next item is taken once the last coefficient is registered.
// Reset: rst_ni clears the sequencer, the divider control and the output valid.
module fraction_to_stern_brocot_path_unit #(
  parameter int unsigned VALUE_BITS = fsbp_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [fsbp_pkg::IN_BITS-1:0]   numerator_i,
  input  logic [fsbp_pkg::IN_BITS-1:0]   denominator_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fsbp_pkg::COEF_BITS-1:0] coefficient_o,
  output logic                           last_coefficient_o,
  output logic                           zero_input_error_o
);

  localparam int unsigned W = VALUE_BITS;
  localparam int unsigned CB = fsbp_pkg::COEF_BITS;
  localparam int unsigned NB = fsbp_pkg::CNT_BITS;
  localparam logic [NB-1:0] LastIdx = NB'(fsbp_pkg::MAX_RESULTS - 1);

  fsbp_pkg::fsbp_state_e state_q, state_d;

  // Working pair: hi is the dividend, lo the divisor of the next step
  logic [W-1:0]  hi_q, lo_q;
  logic [NB-1:0] n_q;

  // Output register
  logic          out_valid_q;
  logic [CB-1:0] coef_q;
  logic          last_q;
  logic          err_q;

  // Divider interface
  logic          div_start;
  logic          div_done;
  logic [W-1:0]  div_quo;
  logic [W-1:0]  div_rem;

  // Control from the output decode
  logic          in_accept;
  logic          slot_free;
  logic          emit;
  logic [CB-1:0] emit_coef;
  logic          emit_last;
  logic          emit_err;
  logic          swap;
  logic          advance;

  // Decode of the working pair and of the finished quotient
  logic          pair_zero;
  logic          pair_eq;
  logic          pair_lt;
  logic          run_done;
  logic [W-1:0]  num_m, den_m;
  logic [CB-1:0] quo_coef;

  assign in_accept = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  // Bring the port fields to the working width: truncate or zero-extend
  always_comb begin
    num_m = '0;
    den_m = '0;
    for (int i = 0; i < W; i++) begin
      if (i < fsbp_pkg::IN_BITS) begin
        num_m[i] = numerator_i[i];
        den_m[i] = denominator_i[i];
      end
    end
  end

  // Coefficient is the low bits of the quotient
  always_comb begin
    quo_coef = '0;
    for (int i = 0; i < CB; i++) begin
      if (i < W) begin
        quo_coef[i] = div_quo[i];
      end
    end
  end

  assign pair_zero = (hi_q == '0) || (lo_q == '0);
  assign pair_eq   = (hi_q == lo_q);
  assign pair_lt   = (hi_q < lo_q);
  assign run_done  = (div_rem == '0) || (n_q >= LastIdx);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fsbp_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = fsbp_pkg::ST_CHECK;
      end
      fsbp_pkg::ST_CHECK: begin
        priority if (pair_zero || pair_eq) begin
          if (slot_free) state_d = fsbp_pkg::ST_IDLE;
        end else if (pair_lt) begin
          if (slot_free) state_d = fsbp_pkg::ST_LOAD;
        end else begin
          state_d = fsbp_pkg::ST_LOAD;
        end
      end
      fsbp_pkg::ST_LOAD: state_d = fsbp_pkg::ST_DIV;
      fsbp_pkg::ST_DIV: begin
        if (div_done) state_d = fsbp_pkg::ST_PUT;
      end
      fsbp_pkg::ST_PUT: begin
        if (slot_free) state_d = run_done ? fsbp_pkg::ST_IDLE : fsbp_pkg::ST_LOAD;
      end
      default: state_d = fsbp_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    emit       = 1'b0;
    emit_coef  = '0;
    emit_last  = 1'b0;
    emit_err   = 1'b0;
    swap       = 1'b0;
    advance    = 1'b0;
    unique case (state_q)
      fsbp_pkg::ST_IDLE: in_ready_o = 1'b1;
      fsbp_pkg::ST_CHECK: begin
        // Zero input, equal pair or a leading zero coefficient each emit from here once the output slot is free
        emit      = slot_free && (pair_zero || pair_eq || pair_lt);
        emit_coef = (pair_eq && !pair_zero) ? CB'(1) : '0;
        emit_last = pair_zero || pair_eq;
        emit_err  = pair_zero;
        swap      = slot_free && pair_lt && !pair_zero;
      end
      fsbp_pkg::ST_LOAD: div_start = 1'b1;
      fsbp_pkg::ST_DIV: ;
      fsbp_pkg::ST_PUT: begin
        emit      = slot_free;
        emit_coef = quo_coef;
        emit_last = run_done;
        advance   = slot_free && !run_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fsbp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // Count results emitted so far; the leading zero counts as one
      if (in_accept) begin
        n_q <= '0;
      end else if (swap) begin
        n_q <= NB'(1);
      end else if (advance) begin
        n_q <= n_q + 1'b1;
      end
    end
  end

  // Payload: hold the pair, swap on a leading zero, advance by Euclid step
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      hi_q <= num_m;
      lo_q <= den_m;
    end else if (swap) begin
      hi_q <= lo_q;
      lo_q <= hi_q;
    end else if (advance) begin
      hi_q <= lo_q;
      lo_q <= div_rem;
    end
    if (emit) begin
      coef_q <= emit_coef;
      last_q <= emit_last;
      err_q  <= emit_err;
    end
  end

  fsbp_div #(
    .W(W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (hi_q),
    .divisor_i  (lo_q),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  assign out_valid_o        = out_valid_q;
  assign coefficient_o      = coef_q;
  assign last_coefficient_o = last_q;
  assign zero_input_error_o = err_q;

endmodule

>>> src/fsbp_checker.sv
module fsbp_assertions (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic [fsbp_pkg::IN_BITS-1:0]   numerator_i,
  input logic [fsbp_pkg::IN_BITS-1:0]   denominator_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [fsbp_pkg::COEF_BITS-1:0] coefficient_o,
  input logic                           last_coefficient_o,
  input logic                           zero_input_error_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(coefficient_o) && $stable(last_coefficient_o)
      && $stable(zero_input_error_o))
    else $error("result changed while stalled");

  // An error result stands alone with a zero coefficient
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_input_error_o |-> coefficient_o == '0 && last_coefficient_o)
    else $error("malformed error result");

  // A zero coefficient without error only opens a run
  a_zero_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !zero_input_error_o && coefficient_o == '0 |-> !last_coefficient_o)
    else $error("zero coefficient closes a run");

  // Busy right after taking an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken back to back");

endmodule

bind fraction_to_stern_brocot_path_unit fsbp_assertions u_fsbp_assertions (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .numerator_i        (numerator_i),
  .denominator_i      (denominator_i),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .coefficient_o      (coefficient_o),
  .last_coefficient_o (last_coefficient_o),
  .zero_input_error_o (zero_input_error_o)
);
